@@ rtl/edist_pkg.sv @@
// Package for the edit distance engine: constants, codes, FSM and control types,
// and the saturating helpers of the cost update. No dependencies.
package edist_pkg;

    localparam int MAX_PATTERN_DEF = 31;
    localparam int PATTERN_STORE   = 31;
    localparam int CHAR_W          = 8;
    localparam int COST_W          = 8;
    localparam int LEN_W           = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int PATTERN_WORDS   = 4;
    localparam int POS_W           = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH  = 3'd0,
        CFG_PATTERN_CHARS_0 = 3'd1,
        CFG_PATTERN_CHARS_1 = 3'd2,
        CFG_PATTERN_CHARS_2 = 3'd3,
        CFG_PATTERN_CHARS_3 = 3'd4
    } cfg_index_t;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_END
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } row_ctl_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] v,
                                                  input logic inc);
        logic [COST_W-1:0] r;
        if (v == {COST_W{1'b1}})
            r = v;
        else
            r = v + {{(COST_W-1){1'b0}}, inc};
        return r;
    endfunction

    function automatic logic [COST_W-1:0] min3(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b,
                                               input logic [COST_W-1:0] c);
        logic [COST_W-1:0] m;
        m = (a < b) ? a : b;
        if (c < m)
            m = c;
        return m;
    endfunction

endpackage

@@ rtl/edist_if.sv @@
// Channel interfaces of the edit distance engine: text beats in, distance beats out.
// Depends on edist_pkg for field widths.
interface edist_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [edist_pkg::CHAR_W-1:0]  text_char;

    modport source (output valid, output kind, output text_char, input ready);
    modport sink   (input valid, input kind, input text_char, output ready);
endinterface

interface edist_out_if;
    logic                          valid;
    logic                          ready;
    logic [edist_pkg::COST_W-1:0]  distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

@@ rtl/edist_cfg_regs.sv @@
// Configuration registers: pattern length and the packed pattern characters,
// with the character lookup for the row walk. Depends on edist_pkg.
module edist_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [edist_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [edist_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [edist_pkg::POS_W-1:0]         pos,
    output logic [edist_pkg::CHAR_W-1:0]        pattern_char,
    output logic [edist_pkg::LEN_W-1:0]         pattern_length
);
    import edist_pkg::*;

    logic [LEN_W-1:0]                         length_reg;
    logic [PATTERN_WORDS-1:0][7:0][CHAR_W-1:0] pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= '0;
            pattern_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH:  length_reg     <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_CHARS_0: pattern_reg[0] <= cfg_data;
                CFG_PATTERN_CHARS_1: pattern_reg[1] <= cfg_data;
                CFG_PATTERN_CHARS_2: pattern_reg[2] <= cfg_data;
                CFG_PATTERN_CHARS_3: pattern_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pattern_char   = pattern_reg[pos[4:3]][pos[2:0]];
    assign pattern_length = length_reg;

endmodule

@@ rtl/edist_row_mem.sv @@
// Cost row store: single-port-per-side synchronous RAM with registered read,
// plus per-entry valid bits; an unwritten entry reads as its index. Depends on edist_pkg.
module edist_row_mem #(
    parameter int DEPTH  = edist_pkg::MAX_PATTERN_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  edist_pkg::row_ctl_t            ctl,
    input  logic [ADDR_W-1:0]              rd_addr,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [edist_pkg::COST_W-1:0]   wr_data,
    output logic [edist_pkg::COST_W-1:0]   rd_value
);
    import edist_pkg::*;

    logic [COST_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [COST_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (ctl.clear)
                valid_reg <= '0;
            else if (ctl.wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_addr_reg  <= rd_addr;
            end
        end
    end

    // entry i reads as i until written (the index truncated to COST_W bits)
    assign rd_value = rd_valid_reg ? rd_data_reg : COST_W'(rd_addr_reg);

endmodule

@@ rtl/edit_distance_engine.sv @@
// Top level of the streaming edit distance engine: sequencer, cost datapath,
// output register. Depends on edist_pkg, edist_if, edist_cfg_regs, edist_row_mem.
//
// A text beat (kind 0) walks the cost row held in a synchronous RAM with registered read, one
// entry per cycle: read entry j+1, form the new cost, write it back, while the next
// read is already in flight. A text beat therefore occupies the block for the whole
// walk over entries 1 to min(MAX_PATTERN, 31), as the row RAM has a single read and
// write port. An end beat (kind 1) reads the row at the pattern length and, once the
// output register is free, loads the distance into that register; the row returns to
// 0..length at once through per-entry valid bits, so no clearing pass is needed after
// reset or between texts. Text beats are taken while a distance waits at the output.
module edit_distance_engine #(
    parameter int MAX_PATTERN = edist_pkg::MAX_PATTERN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    edist_in_if.sink                            text,
    edist_out_if.source                         result,
    input  logic                                cfg_we,
    input  logic [edist_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [edist_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import edist_pkg::*;

    localparam int ROW_DEPTH = MAX_PATTERN + 1;
    localparam int IDX_W     = $clog2(ROW_DEPTH);
    localparam int ACTIVE    = (MAX_PATTERN < PATTERN_STORE) ? MAX_PATTERN : PATTERN_STORE;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [COST_W-1:0] left_reg, left_next;
    logic [COST_W-1:0] diag_reg, diag_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [COST_W-1:0] count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [COST_W-1:0] out_data_reg, out_data_next;

    row_ctl_t          row_ctl;
    logic [IDX_W-1:0]  rd_addr;
    logic [COST_W-1:0] rd_value;
    logic [COST_W-1:0] new_cost;
    logic [COST_W-1:0] end_value;
    logic [IDX_W-1:0]  end_addr;
    logic [LEN_W-1:0]  pattern_length;
    logic [CHAR_W-1:0] pattern_char;
    logic [POS_W-1:0]  pos;
    logic              accept;
    logic              out_free;

    edist_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pos            (pos),
        .pattern_char   (pattern_char),
        .pattern_length (pattern_length)
    );

    edist_row_mem #(
        .DEPTH  (ROW_DEPTH),
        .ADDR_W (IDX_W)
    ) u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (row_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (addr_reg),
        .wr_data  (new_cost),
        .rd_value (rd_value)
    );

    assign text.ready      = (state_reg == ST_IDLE);
    assign accept          = text.valid && text.ready;
    assign result.valid    = out_valid_reg;
    assign result.distance = out_data_reg;
    assign out_free        = !out_valid_reg || result.ready;

    always_comb
    begin
        if (32'(pattern_length) > MAX_PATTERN)
            end_addr = IDX_W'(MAX_PATTERN);
        else
            end_addr = IDX_W'(pattern_length);
    end

    assign pos       = POS_W'(32'(addr_reg) - 32'd1);
    assign new_cost  = min3(sat_add(left_reg, 1'b1), sat_add(rd_value, 1'b1),
                            sat_add(diag_reg, (char_reg != pattern_char)));
    assign end_value = (addr_reg == '0) ? count_reg : rd_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        char_reg     <= char_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        char_next      = char_reg;
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !result.ready;
        row_ctl        = '0;
        rd_addr        = addr_reg + IDX_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_ctl.rd_en = 1'b1;
                    if (text.kind == KIND_END)
                    begin
                        rd_addr    = end_addr;
                        addr_next  = end_addr;
                        state_next = ST_END;
                    end
                    else
                    begin
                        rd_addr    = IDX_W'(1);
                        addr_next  = IDX_W'(1);
                        count_next = sat_add(count_reg, 1'b1);
                        left_next  = sat_add(count_reg, 1'b1);
                        diag_next  = count_reg;
                        char_next  = text.text_char;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                row_ctl.wr_en = 1'b1;
                left_next     = new_cost;
                diag_next     = rd_value;
                if (addr_reg == IDX_W'(ACTIVE))
                    state_next = ST_IDLE;
                else
                begin
                    row_ctl.rd_en = 1'b1;
                    addr_next     = addr_reg + IDX_W'(1);
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_data_next  = end_value;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    row_ctl.clear  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_END))
        else $error("distance beat raised outside end handling");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROW) |-> !row_ctl.wr_en)
        else $error("row written outside a row walk");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW) |-> (addr_reg != '0) && (32'(addr_reg) <= ACTIVE))
        else $error("row walk address out of range");

    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW) && $past(state_reg == ST_ROW)
            |-> (addr_reg == $past(addr_reg) + IDX_W'(1)))
        else $error("row walk skipped an entry");

endmodule
